FILE: hdl/ifpf_pkg.sv
// Shared types, codes and constants for the interface prefix filter.
`timescale 1ns / 1ps
package ifpf_pkg;

  localparam int IFACE_SLOTS_DEF  = 32;
  localparam int PREFIX_SLOTS_DEF = 64;

  localparam int ID_W     = 8;
  localparam int LEN_W    = 8;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 3;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [LEN_W-1:0] V4_MAX_LEN = LEN_W'(32);
  localparam logic [LEN_W-1:0] V6_MAX_LEN = LEN_W'(128);

  localparam logic [PADDR_W-1:0] REG_FILTER_EN_ADDR = '0;

  typedef enum logic [1:0] {
    OP_ADD_IF  = 2'd0,
    OP_ADD_PFX = 2'd1,
    OP_CHECK   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_BADLEN  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_IF_SCAN,
    S_PF_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   iface;
    logic              fam;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
  } pfx_entry_t;

  typedef struct packed {
    logic                in_ready;
    logic                if_start;
    logic                if_step;
    logic                if_write;
    logic                pf_start;
    logic                pf_step;
    logic                pf_write;
    logic                res_load;
    logic                res_allowed;
    logic [STATUS_W-1:0] res_status;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] op;
    logic       enabled;
    logic       if_hit;
    logic       if_done;
    logic       if_full;
    logic       pf_hit;
    logic       pf_done;
    logic       pf_full;
    logic       len_bad;
    logic       out_free;
  } sts_t;

endpackage

FILE: hdl/ifpf_req_if.sv
// Request channel: one filter operation per request.
`timescale 1ns / 1ps
interface ifpf_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      op;
  logic [ifpf_pkg::ID_W-1:0]       iface_id;
  logic                            is_ipv6;
  logic [ifpf_pkg::LEN_W-1:0]      pfx_len;
  logic [ifpf_pkg::ADDR_W-1:0]     addr_high;
  logic [ifpf_pkg::ADDR_W-1:0]     addr_low;

  modport source (output valid, op, iface_id, is_ipv6, pfx_len, addr_high, addr_low,
                  input ready);
  modport sink (input valid, op, iface_id, is_ipv6, pfx_len, addr_high, addr_low,
                output ready);
endinterface

FILE: hdl/ifpf_rsp_if.sv
// Response channel: verdict and status for each request.
`timescale 1ns / 1ps
interface ifpf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          allowed;
  logic [ifpf_pkg::STATUS_W-1:0] status;

  modport source (output valid, allowed, status, input ready);
  modport sink (input valid, allowed, status, output ready);
endinterface

FILE: hdl/ifpf_ctrl.sv
// Controller state machine sequencing table scans, table writes and responses.
`timescale 1ns / 1ps
module ifpf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  ifpf_pkg::sts_t    sts,
  output ifpf_pkg::cmd_t    cmd
);

  ifpf_pkg::state_t state;
  ifpf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifpf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ifpf_pkg::S_IDLE: begin
        if (sts.accepted) state_next = ifpf_pkg::S_DISPATCH;
      end
      ifpf_pkg::S_DISPATCH: begin
        if ((sts.op == ifpf_pkg::OP_ADD_IF) || (sts.op == ifpf_pkg::OP_ADD_PFX) ||
            ((sts.op == ifpf_pkg::OP_CHECK) && sts.enabled)) begin
          state_next = ifpf_pkg::S_IF_SCAN;
        end else begin
          state_next = ifpf_pkg::S_RESP;
        end
      end
      ifpf_pkg::S_IF_SCAN: begin
        if (sts.if_hit && (sts.op == ifpf_pkg::OP_CHECK)) begin
          state_next = ifpf_pkg::S_PF_SCAN;
        end else if (sts.if_hit || sts.if_done) begin
          state_next = ifpf_pkg::S_RESP;
        end
      end
      ifpf_pkg::S_PF_SCAN: begin
        if (sts.pf_hit || sts.pf_done) state_next = ifpf_pkg::S_RESP;
      end
      ifpf_pkg::S_RESP: begin
        if (sts.out_free) state_next = ifpf_pkg::S_IDLE;
      end
      default: state_next = ifpf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_status = ifpf_pkg::ST_OK;
    unique case (state)
      ifpf_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      ifpf_pkg::S_DISPATCH: begin
        cmd.if_start = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_allowed = (sts.op == ifpf_pkg::OP_CHECK) && !sts.enabled;
      end
      ifpf_pkg::S_IF_SCAN: begin
        cmd.if_step = 1'b1;
        if (sts.if_hit) begin
          unique case (sts.op)
            ifpf_pkg::OP_ADD_IF: begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ifpf_pkg::ST_DUP;
            end
            ifpf_pkg::OP_ADD_PFX: begin
              cmd.res_load = 1'b1;
              if (sts.pf_full) begin
                cmd.res_status = ifpf_pkg::ST_FULL;
              end else if (sts.len_bad) begin
                cmd.res_status = ifpf_pkg::ST_BADLEN;
              end else begin
                cmd.pf_write = 1'b1;
              end
            end
            ifpf_pkg::OP_CHECK: begin
              cmd.pf_start = 1'b1;
            end
            default: ;
          endcase
        end else if (sts.if_done) begin
          cmd.res_load = 1'b1;
          if (sts.op == ifpf_pkg::OP_ADD_IF) begin
            if (sts.if_full) begin
              cmd.res_status = ifpf_pkg::ST_FULL;
            end else begin
              cmd.if_write = 1'b1;
            end
          end else begin
            cmd.res_status = ifpf_pkg::ST_UNKNOWN;
          end
        end
      end
      ifpf_pkg::S_PF_SCAN: begin
        cmd.pf_step = 1'b1;
        if (sts.pf_hit || sts.pf_done) begin
          cmd.res_load    = 1'b1;
          cmd.res_allowed = sts.pf_hit;
        end
      end
      ifpf_pkg::S_RESP: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/ifpf_dp.sv
// Datapath: request capture, interface and prefix tables, match logic, response register.
`timescale 1ns / 1ps
module ifpf_dp #(
  parameter int IFACE_SLOTS  = ifpf_pkg::IFACE_SLOTS_DEF,
  parameter int PREFIX_SLOTS = ifpf_pkg::PREFIX_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            enabled,
  input  ifpf_pkg::cmd_t  cmd,
  output ifpf_pkg::sts_t  sts,
  ifpf_req_if.sink        req,
  ifpf_rsp_if.source      rsp
);

  localparam int ICW = $clog2(IFACE_SLOTS + 1);
  localparam int IAW = (IFACE_SLOTS > 1) ? $clog2(IFACE_SLOTS) : 1;
  localparam int PCW = $clog2(PREFIX_SLOTS + 1);
  localparam int PAW = (PREFIX_SLOTS > 1) ? $clog2(PREFIX_SLOTS) : 1;

  localparam int IDW = ifpf_pkg::ID_W;
  localparam int LW  = ifpf_pkg::LEN_W;
  localparam int AW  = ifpf_pkg::ADDR_W;

  // captured request
  logic [1:0]     cap_op;
  logic [IDW-1:0] cap_id;
  logic           cap_fam;
  logic [LW-1:0]  cap_len;
  logic [AW-1:0]  cap_hi;
  logic [AW-1:0]  cap_lo;

  logic accept;
  assign accept    = req.valid && cmd.in_ready;
  assign req.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cap_op  <= req.op;
      cap_id  <= req.iface_id;
      cap_fam <= req.is_ipv6;
      cap_len <= req.pfx_len;
      cap_hi  <= req.is_ipv6 ? req.addr_high : '0;
      cap_lo  <= req.is_ipv6 ? req.addr_low : {32'b0, req.addr_low[31:0]};
    end
  end

  // interface table
  logic [IDW-1:0] iface_mem [IFACE_SLOTS];
  logic [ICW-1:0] if_count;
  logic [ICW-1:0] if_cnt;
  logic           if_pend;
  logic [IDW-1:0] if_rd;
  logic           if_issue;

  assign if_issue = cmd.if_step && (if_cnt < if_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      if_count <= '0;
      if_cnt   <= '0;
      if_pend  <= 1'b0;
    end else begin
      if (cmd.if_write) if_count <= if_count + ICW'(1);
      if (cmd.if_start) begin
        if_cnt  <= '0;
        if_pend <= 1'b0;
      end else if (cmd.if_step) begin
        if_pend <= if_issue;
        if (if_issue) if_cnt <= if_cnt + ICW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.if_write) iface_mem[if_count[IAW-1:0]] <= cap_id;
    if (if_issue) if_rd <= iface_mem[if_cnt[IAW-1:0]];
  end

  // prefix table
  ifpf_pkg::pfx_entry_t pfx_mem [PREFIX_SLOTS];
  ifpf_pkg::pfx_entry_t pf_rd;
  logic [PCW-1:0] pf_count;
  logic [PCW-1:0] pf_cnt;
  logic           pf_pend;
  logic           pf_issue;

  assign pf_issue = cmd.pf_step && (pf_cnt < pf_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      pf_count <= '0;
      pf_cnt   <= '0;
      pf_pend  <= 1'b0;
    end else begin
      if (cmd.pf_write) pf_count <= pf_count + PCW'(1);
      if (cmd.pf_start) begin
        pf_cnt  <= '0;
        pf_pend <= 1'b0;
      end else if (cmd.pf_step) begin
        pf_pend <= pf_issue;
        if (pf_issue) pf_cnt <= pf_cnt + PCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pf_write) begin
      pfx_mem[pf_count[PAW-1:0]] <= '{iface: cap_id, fam: cap_fam, len: cap_len,
                                      hi: cap_hi, lo: cap_lo};
    end
    if (pf_issue) pf_rd <= pfx_mem[pf_cnt[PAW-1:0]];
  end

  // prefix compare on the registered entry
  logic [31:0]   m32;
  logic [AW-1:0] mh;
  logic [AW-1:0] ml;
  logic          v4_ok;
  logic          v6_ok;
  logic          addr_ok;

  always_comb begin
    m32 = ~(32'hFFFF_FFFF >> pf_rd.len);
    mh  = ~({AW{1'b1}} >> pf_rd.len);
    ml  = (pf_rd.len > LW'(64)) ? ~({AW{1'b1}} >> (pf_rd.len - LW'(64))) : '0;
    v4_ok   = ((cap_lo[31:0] ^ pf_rd.lo[31:0]) & m32) == '0;
    v6_ok   = (((cap_hi ^ pf_rd.hi) & mh) == '0) && (((cap_lo ^ pf_rd.lo) & ml) == '0);
    addr_ok = cap_fam ? v6_ok : v4_ok;
  end

  // result and response registers
  logic                          res_allowed;
  logic [ifpf_pkg::STATUS_W-1:0] res_status;
  logic                          out_valid;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_allowed <= cmd.res_allowed;
      res_status  <= cmd.res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.allowed <= res_allowed;
      rsp.status  <= res_status;
    end
  end

  assign rsp.valid = out_valid;

  always_comb begin
    sts          = '0;
    sts.accepted = accept;
    sts.op       = cap_op;
    sts.enabled  = enabled;
    sts.if_hit   = if_pend && (if_rd == cap_id);
    sts.if_done  = !if_pend && (if_cnt >= if_count);
    sts.if_full  = (if_count == ICW'(IFACE_SLOTS));
    sts.pf_hit   = pf_pend && (pf_rd.iface == cap_id) && (pf_rd.fam == cap_fam) && addr_ok;
    sts.pf_done  = !pf_pend && (pf_cnt >= pf_count);
    sts.pf_full  = (pf_count == PCW'(PREFIX_SLOTS));
    sts.len_bad  = cap_len > (cap_fam ? ifpf_pkg::V6_MAX_LEN : ifpf_pkg::V4_MAX_LEN);
    sts.out_free = !out_valid || rsp.ready;
  end

endmodule

FILE: hdl/interface_prefix_filter_top.sv
// Requests with op 3 and disabled checks go from dispatch straight to the response state; add
// and enabled check requests first scan the interface table, and enabled checks on a listed
// interface then scan the prefix table. One request is handled at a time, and each table
// is scanned through its single read port. Synchronous reset empties both tables (contents
// are not cleared), clears filter_enabled and drops any pending response.
`timescale 1ns / 1ps
module interface_prefix_filter_top #(
  parameter int IFACE_SLOTS  = ifpf_pkg::IFACE_SLOTS_DEF,
  parameter int PREFIX_SLOTS = ifpf_pkg::PREFIX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  ifpf_req_if.sink                      req,
  ifpf_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ifpf_pkg::PADDR_W-1:0]  paddr,
  input  logic [ifpf_pkg::PDATA_W-1:0]  pwdata,
  output logic [ifpf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic           filter_enabled;
  ifpf_pkg::cmd_t cmd;
  ifpf_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enabled <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == ifpf_pkg::REG_FILTER_EN_ADDR)) begin
      filter_enabled <= pwdata[0];
    end
  end

  assign prdata = (paddr == ifpf_pkg::REG_FILTER_EN_ADDR) ?
                  {{(ifpf_pkg::PDATA_W-1){1'b0}}, filter_enabled} : '0;

  ifpf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ifpf_dp #(
    .IFACE_SLOTS  (IFACE_SLOTS),
    .PREFIX_SLOTS (PREFIX_SLOTS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .enabled (filter_enabled),
    .cmd     (cmd),
    .sts     (sts),
    .req     (req),
    .rsp     (rsp)
  );

endmodule

FILE: hdl/ifpf_checker.sv
// Port-level assertions for the interface prefix filter and their bind.
`timescale 1ns / 1ps
module ifpf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_allowed,
  input logic [ifpf_pkg::STATUS_W-1:0] rsp_status,
  input logic                          pready
);

  a_rsp_clear_after_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_allowed_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_allowed |-> rsp_status == ifpf_pkg::ST_OK)
    else $error("allowed response carries error status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status <= ifpf_pkg::ST_BADLEN)
    else $error("status code out of range");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allowed) && $stable(rsp_status))
    else $error("stalled response changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind interface_prefix_filter_top ifpf_checker u_ifpf_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_allowed (rsp.allowed),
  .rsp_status  (rsp.status),
  .pready      (pready)
);
